### rtl/dcsfd_pkg.sv
// Shared types, constants and the temperature conversion of the frame decoder.
package dcsfd_pkg;

	typedef enum logic [1:0] {
		OP_START   = 2'd0,
		OP_PULSE   = 2'd1,
		OP_TIMEOUT = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ERR_OK         = 3'd0,
		ERR_INCOMPLETE = 3'd1,
		ERR_STROBE     = 3'd2,
		ERR_BIT_WIDTH  = 3'd3,
		ERR_PARITY     = 3'd4,
		ERR_ZERO_VALUE = 3'd5
	} err_t;

	localparam logic [2:0] REG_ONE_MIN    = 3'd0;
	localparam logic [2:0] REG_ONE_MAX    = 3'd1;
	localparam logic [2:0] REG_STROBE_MIN = 3'd2;
	localparam logic [2:0] REG_STROBE_MAX = 3'd3;
	localparam logic [2:0] REG_ZERO_MIN   = 3'd4;
	localparam logic [2:0] REG_ZERO_MAX   = 3'd5;

	localparam logic [7:0] RST_ONE_MIN    = 8'd15;
	localparam logic [7:0] RST_ONE_MAX    = 8'd35;
	localparam logic [7:0] RST_STROBE_MIN = 8'd39;
	localparam logic [7:0] RST_STROBE_MAX = 8'd60;
	localparam logic [7:0] RST_ZERO_MIN   = 8'd63;
	localparam logic [7:0] RST_ZERO_MAX   = 8'd96;

	localparam logic [4:0]  FRAME_PULSES = 5'd20;
	localparam logic [4:0]  POS_STROBE_HI = 5'd0;
	localparam logic [4:0]  POS_STROBE_LO = 5'd10;
	localparam logic [4:0]  POS_PARITY_HI = 5'd9;
	localparam logic [4:0]  POS_PARITY_LO = 5'd19;
	localparam logic [7:0]  BAD_LIMIT    = 8'd255;
	localparam logic [11:0] TEMP_SCALE   = 12'd2500;
	localparam logic [15:0] TEMP_KNEE    = 16'd767;
	localparam logic [15:0] TEMP_OFFSET  = 16'd22315;

	typedef struct packed {
		op_t  op;
		logic strobe_ok;
		logic zero_ok;
		logic one_ok;
	} q_entry_t;

	typedef struct packed {
		logic [15:0] raw;
		err_t        err;
		logic [7:0]  bad;
	} result_t;

	typedef struct packed {
		logic       sampling;
		logic [4:0] pulse_index;
	} frame_stat_t;

	function automatic logic [15:0] to_temperature(input logic [15:0] raw);
		logic [16:0] r;
		logic [28:0] p;
		r = {1'b0, raw} + 17'(raw >= TEMP_KNEE);
		p = 29'(r) * 29'(TEMP_SCALE);
		return p[23:8] + TEMP_OFFSET;
	endfunction

endpackage

### rtl/duty_cycle_sensor_frame_decoder_core.sv
// Top level of the pulse-width sensor frame decoder.
// The completing beat passes the queue and the back-end result register before out_valid rises.
// Throughput: one input beat per cycle while the queue has room; the back end retires one
// queued item each cycle while its result register is free.
// The queue of QUEUE_DEPTH entries lets the front end keep taking beats while the output stalls.
// Reset clears the frame state, the bad-reading count and the queue; windows return to defaults.
module duty_cycle_sensor_frame_decoder_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  pulse_width,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] raw_value,
	output logic [15:0] temperature,
	output logic        valid_res,
	output logic [2:0]  error_code,
	output logic [7:0]  bad_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import dcsfd_pkg::*;

	logic        push_valid, push_ready, pop_valid, pop_ready;
	q_entry_t    push_data, pop_data;
	logic        res_valid_s1, res_ready;
	result_t     res_s1;
	frame_stat_t stat;

	dcsfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.pulse_width(pulse_width),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	dcsfd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	dcsfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_data    (pop_data),
		.res_valid_s1(res_valid_s1),
		.res_ready   (res_ready),
		.res_s1      (res_s1),
		.stat        (stat)
	);

	dcsfd_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid_s1),
		.res_ready  (res_ready),
		.res        (res_s1),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.raw_value  (raw_value),
		.temperature(temperature),
		.valid_res  (valid_res),
		.error_code (error_code),
		.bad_count  (bad_count)
	);

	a_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		stat.sampling |-> stat.pulse_index < FRAME_PULSES)
		else $error("pulse index beyond frame while sampling");

	a_valid_means_good: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> error_code == ERR_OK && raw_value != 16'd0)
		else $error("valid result without a clean nonzero frame");

	a_bad_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> raw_value == 16'd0 && temperature == 16'd0)
		else $error("failed frame carries a value");

	a_result_only_from_frame: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_s1) |-> $past(stat.sampling))
		else $error("result raised without a frame in progress");

endmodule

### rtl/dcsfd_front.sv
// Front end: configuration registers and pulse-width window classification.
module dcsfd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          opcode,
	input  logic [7:0]          pulse_width,
	output logic                push_valid,
	input  logic                push_ready,
	output dcsfd_pkg::q_entry_t push_data
);
	import dcsfd_pkg::*;

	logic [7:0] one_min_q, one_max_q, strobe_min_q, strobe_max_q, zero_min_q, zero_max_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_min_q    <= RST_ONE_MIN;
			one_max_q    <= RST_ONE_MAX;
			strobe_min_q <= RST_STROBE_MIN;
			strobe_max_q <= RST_STROBE_MAX;
			zero_min_q   <= RST_ZERO_MIN;
			zero_max_q   <= RST_ZERO_MAX;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ONE_MIN:    one_min_q    <= cfg_data;
				REG_ONE_MAX:    one_max_q    <= cfg_data;
				REG_STROBE_MIN: strobe_min_q <= cfg_data;
				REG_STROBE_MAX: strobe_max_q <= cfg_data;
				REG_ZERO_MIN:   zero_min_q   <= cfg_data;
				REG_ZERO_MAX:   zero_max_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		push_data.op        = op_t'(opcode);
		push_data.strobe_ok = (pulse_width >= strobe_min_q) && (pulse_width <= strobe_max_q);
		push_data.zero_ok   = (pulse_width >= zero_min_q) && (pulse_width <= zero_max_q);
		push_data.one_ok    = (pulse_width >= one_min_q) && (pulse_width <= one_max_q);
	end

	assign push_valid = in_valid;
	assign in_ready   = push_ready;

endmodule

### rtl/dcsfd_queue.sv
// Small register queue between the classifying front end and the frame back end.
module dcsfd_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  dcsfd_pkg::q_entry_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output dcsfd_pkg::q_entry_t pop_data
);
	import dcsfd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	q_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/dcsfd_back.sv
// Back end: frame assembly, fault ranking and bad-reading count.
module dcsfd_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	output logic                   pop_ready,
	input  dcsfd_pkg::q_entry_t    pop_data,
	output logic                   res_valid_s1,
	input  logic                   res_ready,
	output dcsfd_pkg::result_t     res_s1,
	output dcsfd_pkg::frame_stat_t stat
);
	import dcsfd_pkg::*;

	logic       sampling_q, sampling_n;
	logic [4:0] index_q, index_n;
	logic [7:0] high_q, high_n, low_q, low_n;
	logic       parity_q, parity_n;
	logic       strobe_fault_q, strobe_fault_n;
	err_t       first_fault_q, first_fault_n;
	logic [7:0] bad_q, bad_n;
	logic       fin;
	err_t       fin_code, err;
	logic       is_one, pop;
	logic [15:0] raw_n;
	result_t    res_n;

	assign pop       = pop_valid && pop_ready;
	assign pop_ready = !res_valid_s1 || res_ready;
	assign is_one    = !pop_data.zero_ok && pop_data.one_ok;

	always_comb begin
		sampling_n     = sampling_q;
		index_n        = index_q;
		high_n         = high_q;
		low_n          = low_q;
		parity_n       = parity_q;
		strobe_fault_n = strobe_fault_q;
		first_fault_n  = first_fault_q;
		bad_n          = bad_q;
		fin            = 1'b0;
		fin_code       = ERR_OK;
		unique case (pop_data.op)
			OP_START: begin
				if (!sampling_q) begin
					sampling_n     = 1'b1;
					index_n        = '0;
					high_n         = '0;
					low_n          = '0;
					parity_n       = 1'b0;
					strobe_fault_n = 1'b0;
					first_fault_n  = ERR_OK;
				end
			end
			OP_PULSE: begin
				if (sampling_q) begin
					if (index_q == POS_STROBE_HI || index_q == POS_STROBE_LO) begin
						if (!pop_data.strobe_ok) begin
							strobe_fault_n = 1'b1;
						end
						parity_n = 1'b0;
					end else if (index_q == POS_PARITY_HI || index_q == POS_PARITY_LO) begin
						if (first_fault_q == ERR_OK) begin
							if (pop_data.zero_ok) begin
								if (parity_q) begin
									first_fault_n = ERR_PARITY;
								end
							end else if (pop_data.one_ok) begin
								if (!parity_q) begin
									first_fault_n = ERR_PARITY;
								end
							end else begin
								first_fault_n = ERR_BIT_WIDTH;
							end
						end
					end else begin
						if (index_q < POS_STROBE_LO) begin
							high_n = {high_q[6:0], is_one};
						end else begin
							low_n = {low_q[6:0], is_one};
						end
						if (is_one) begin
							parity_n = !parity_q;
						end
						if (!pop_data.zero_ok && !pop_data.one_ok
							&& first_fault_q == ERR_OK) begin
							first_fault_n = ERR_BIT_WIDTH;
						end
					end
					index_n = index_q + 1'b1;
					if (index_n >= FRAME_PULSES) begin
						fin = 1'b1;
					end
				end
			end
			OP_TIMEOUT: begin
				if (sampling_q) begin
					fin      = 1'b1;
					fin_code = ERR_INCOMPLETE;
				end
			end
			OP_CLEAR: begin
				bad_n = '0;
			end
			default: begin
			end
		endcase

		raw_n = {high_n, low_n};
		err   = fin_code;
		if (err == ERR_OK) begin
			if (strobe_fault_n) begin
				err = ERR_STROBE;
			end else if (first_fault_n != ERR_OK) begin
				err = first_fault_n;
			end else if (raw_n == '0) begin
				err = ERR_ZERO_VALUE;
			end
		end
		if (fin) begin
			sampling_n = 1'b0;
			if (err != ERR_OK && bad_q != BAD_LIMIT) begin
				bad_n = bad_q + 1'b1;
			end
		end
		res_n.raw = (err == ERR_OK) ? raw_n : '0;
		res_n.err = err;
		res_n.bad = bad_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sampling_q     <= 1'b0;
			index_q        <= '0;
			high_q         <= '0;
			low_q          <= '0;
			parity_q       <= 1'b0;
			strobe_fault_q <= 1'b0;
			first_fault_q  <= ERR_OK;
			bad_q          <= '0;
			res_valid_s1   <= 1'b0;
		end else begin
			if (pop) begin
				sampling_q     <= sampling_n;
				index_q        <= index_n;
				high_q         <= high_n;
				low_q          <= low_n;
				parity_q       <= parity_n;
				strobe_fault_q <= strobe_fault_n;
				first_fault_q  <= first_fault_n;
				bad_q          <= bad_n;
				res_valid_s1   <= fin;
			end else if (res_ready) begin
				res_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && fin) begin
			res_s1 <= res_n;
		end
	end

	assign stat.sampling    = sampling_q;
	assign stat.pulse_index = index_q;

endmodule

### rtl/dcsfd_out.sv
// Output stage: temperature conversion and the result register.
module dcsfd_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid,
	output logic               res_ready,
	input  dcsfd_pkg::result_t res,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        raw_value,
	output logic [15:0]        temperature,
	output logic               valid_res,
	output logic [2:0]         error_code,
	output logic [7:0]         bad_count
);
	import dcsfd_pkg::*;

	logic        take;
	logic [15:0] temp_n;

	assign res_ready = !out_valid || out_ready;
	assign take      = res_valid && res_ready;
	assign temp_n    = (res.err == ERR_OK) ? to_temperature(res.raw) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_ready) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			raw_value   <= res.raw;
			temperature <= temp_n;
			valid_res   <= (res.err == ERR_OK);
			error_code  <= res.err;
			bad_count   <= res.bad;
		end
	end

endmodule
